### rtl/ffea_pkg.sv
// ----------------------------------------------------------------------------
// ffea_pkg: shared types and constants for the first-fit extent allocator
// Extent table geometry, status and command codes, sequencer states and the
// control words passed between the sequencer, the adder and the table memory.
// ----------------------------------------------------------------------------
`default_nettype none

package ffea_pkg;

  localparam int MAP_ENTRIES = 64;
  localparam int ADDR_W      = 16;
  localparam int IDX_W       = $clog2(MAP_ENTRIES);
  localparam int SPAN_W      = ADDR_W + 1;
  localparam int ALU_W       = ADDR_W + 2;

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [SPAN_W-1:0] span_t;
  typedef logic [IDX_W-1:0]  idx_t;

  // number of table slots that may hold an extent
  localparam idx_t USABLE_SLOTS = idx_t'(MAP_ENTRIES - 1);
  // one past the last address
  localparam span_t ADDR_SPAN   = {1'b1, {ADDR_W{1'b0}}};

  typedef struct packed {
    addr_t base;
    addr_t len;
  } extent_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_NO_FIT = 2'd1,
    ST_FULL   = 2'd2,
    ST_ZERO   = 2'd3
  } status_t;

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_t;

  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_t;

  typedef struct packed {
    alu_op_t op;
    span_t   a;
    span_t   b;
  } alu_req_t;

  typedef struct packed {
    logic    en;
    idx_t    addr;
    extent_t data;
  } mem_wr_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_AL_RD,
    S_AL_CHK,
    S_AL_UPD,
    S_FR_CLIP,
    S_FR_CLIP2,
    S_FR_RD,
    S_FR_CHK,
    S_FR_PREV,
    S_FR_MPREV,
    S_FR_MDEC,
    S_FR_NEXT,
    S_SHD_RD,
    S_SHD_WR,
    S_SHU_RD,
    S_SHU_WR,
    S_RESP
  } state_t;

endpackage

`default_nettype wire

### rtl/ffea_alu.sv
// ----------------------------------------------------------------------------
// ffea_alu: shared add/subtract unit
// One adder serves every extent address and length sum, difference and ordering test of the sequencer.
// Also gives the sum saturated to the extent length width.
// ----------------------------------------------------------------------------
`default_nettype none

module ffea_alu
  import ffea_pkg::*;
(
  input  alu_req_t             req,
  output logic [ALU_W-1:0]     res,
  output logic                 borrow,
  output addr_t                sat
);

  logic [ALU_W-1:0] a_ext;
  logic [ALU_W-1:0] b_ext;

  assign a_ext = {1'b0, req.a};
  assign b_ext = {1'b0, req.b};

  always_comb begin
    case (req.op)
      ALU_ADD: res = a_ext + b_ext;
      ALU_SUB: res = a_ext - b_ext;
      default: res = a_ext + b_ext;
    endcase
  end

  // top bit set after a subtract means a < b
  assign borrow = res[ALU_W-1];
  assign sat    = (|res[ALU_W-1:ADDR_W]) ? {ADDR_W{1'b1}} : res[ADDR_W-1:0];

endmodule

`default_nettype wire

### rtl/ffea_mem.sv
// ----------------------------------------------------------------------------
// ffea_mem: extent table storage
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ffea_mem
  import ffea_pkg::*;
(
  input  logic    clk,
  input  mem_wr_t wr,
  input  idx_t    rd_addr,
  output extent_t rd_data
);

  extent_t mem [MAP_ENTRIES];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

### rtl/first_fit_extent_allocator.sv
// ----------------------------------------------------------------------------
// first_fit_extent_allocator: first-fit free extent map
// Keeps free extents sorted by base; allocates first fit, frees with merge.
// ----------------------------------------------------------------------------
// Usage:
//   A request word (in_command, in_request_size, in_free_base) is taken at a
//   rising edge with start high and busy low. busy stays high until the result
//   word has been shown. The result (out_granted_base, out_status) is on the
//   out_ ports for exactly one cycle with out_valid high; the receiver cannot
//   stall it, it must take the word in that cycle.
//   A zero-size request answers in the cycle after acceptance. Otherwise the
//   table is walked through a single registered read port, a read state and
//   a check state per entry visited, and a removal or insertion shifts
//   entries one at a time, a read state and a write state per entry moved,
//   plus fixed work through the shared adder. One request is in flight at a
//   time, and the next word can be taken in the cycle after the result strobe.
//   Reset (rst_n low, synchronous) empties the table at once through the
//   entry count: no clearing pass is run. The table starts empty and is
//   seeded by free requests.
// ----------------------------------------------------------------------------
`default_nettype none

module first_fit_extent_allocator
  import ffea_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_command,
  input  logic [15:0] in_request_size,
  input  logic [15:0] in_free_base,
  output logic        out_valid,
  output logic [15:0] out_granted_base,
  output logic [1:0]  out_status
);

  state_t  state_r, state_nxt;
  idx_t    used_r, used_nxt;
  idx_t    idx_r, idx_nxt;
  idx_t    ptr_r, ptr_nxt;
  addr_t   size_r, size_nxt;
  addr_t   base_r, base_nxt;
  span_t   end_r, end_nxt;
  extent_t prev_r, prev_nxt;
  extent_t next_r, next_nxt;
  logic    has_next_r, has_next_nxt;
  addr_t   granted_r, granted_nxt;
  status_t status_r, status_nxt;

  alu_req_t          alu_req;
  logic [ALU_W-1:0]  alu_res;
  logic              alu_borrow;
  addr_t             alu_sat;

  mem_wr_t mem_wr;
  idx_t    mem_rd_addr;
  extent_t mem_rd;

  logic [IDX_W:0] ptr_inc_w;
  logic           next_hit;

  ffea_alu u_alu (
    .req    (alu_req),
    .res    (alu_res),
    .borrow (alu_borrow),
    .sat    (alu_sat)
  );

  ffea_mem u_mem (
    .clk     (clk),
    .wr      (mem_wr),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd)
  );

  assign ptr_inc_w = {1'b0, ptr_r} + 1'b1;
  assign next_hit  = has_next_r && (end_r == {1'b0, next_r.base});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      used_r  <= '0;
    end else begin
      state_r <= state_nxt;
      used_r  <= used_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    ptr_r      <= ptr_nxt;
    size_r     <= size_nxt;
    base_r     <= base_nxt;
    end_r      <= end_nxt;
    prev_r     <= prev_nxt;
    next_r     <= next_nxt;
    has_next_r <= has_next_nxt;
    granted_r  <= granted_nxt;
    status_r   <= status_nxt;
  end

  always_comb begin
    state_nxt    = state_r;
    used_nxt     = used_r;
    idx_nxt      = idx_r;
    ptr_nxt      = ptr_r;
    size_nxt     = size_r;
    base_nxt     = base_r;
    end_nxt      = end_r;
    prev_nxt     = prev_r;
    next_nxt     = next_r;
    has_next_nxt = has_next_r;
    granted_nxt  = granted_r;
    status_nxt   = status_r;
    alu_req      = '{op: ALU_ADD, a: '0, b: '0};
    mem_wr       = '0;
    mem_rd_addr  = idx_r;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          size_nxt     = in_request_size;
          base_nxt     = in_free_base;
          granted_nxt  = '0;
          status_nxt   = ST_OK;
          idx_nxt      = '0;
          has_next_nxt = 1'b0;
          if (in_request_size == '0) begin
            status_nxt = ST_ZERO;
            state_nxt  = S_RESP;
          end else if (in_command == CMD_ALLOC) begin
            state_nxt = S_AL_RD;
          end else begin
            state_nxt = S_FR_CLIP;
          end
        end
      end

      // ---- allocate: first-fit scan ----
      S_AL_RD: begin
        if (idx_r == used_r) begin
          status_nxt  = ST_NO_FIT;
          granted_nxt = '0;
          state_nxt   = S_RESP;
        end else begin
          mem_rd_addr = idx_r;
          state_nxt   = S_AL_CHK;
        end
      end

      S_AL_CHK: begin
        alu_req = '{op: ALU_SUB, a: {1'b0, mem_rd.len}, b: {1'b0, size_r}};
        if (!alu_borrow) begin
          granted_nxt = mem_rd.base;
          prev_nxt    = '{base: mem_rd.base, len: alu_res[ADDR_W-1:0]};
          state_nxt   = S_AL_UPD;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = S_AL_RD;
        end
      end

      S_AL_UPD: begin
        alu_req = '{op: ALU_ADD, a: {1'b0, prev_r.base}, b: {1'b0, size_r}};
        if (prev_r.len == '0) begin
          // extent used up: compact the table over it
          ptr_nxt   = idx_r;
          state_nxt = S_SHD_RD;
        end else begin
          mem_wr    = '{en: 1'b1, addr: idx_r,
                        data: '{base: alu_res[ADDR_W-1:0], len: prev_r.len}};
          state_nxt = S_RESP;
        end
      end

      // ---- free: clip, locate, merge or insert ----
      S_FR_CLIP: begin
        alu_req = '{op: ALU_ADD, a: {1'b0, base_r}, b: {1'b0, size_r}};
        if (alu_res[ADDR_W] && (|alu_res[ADDR_W-1:0])) begin
          state_nxt = S_FR_CLIP2;
        end else begin
          end_nxt   = alu_res[SPAN_W-1:0];
          state_nxt = S_FR_RD;
        end
      end

      S_FR_CLIP2: begin
        // range runs past the address space: trim it to end there
        alu_req   = '{op: ALU_SUB, a: ADDR_SPAN, b: {1'b0, base_r}};
        size_nxt  = alu_res[ADDR_W-1:0];
        end_nxt   = ADDR_SPAN;
        state_nxt = S_FR_RD;
      end

      S_FR_RD: begin
        if (idx_r == used_r) begin
          state_nxt = S_FR_PREV;
        end else begin
          mem_rd_addr = idx_r;
          state_nxt   = S_FR_CHK;
        end
      end

      S_FR_CHK: begin
        alu_req = '{op: ALU_SUB, a: {1'b0, base_r}, b: {1'b0, mem_rd.base}};
        if (!alu_borrow) begin
          prev_nxt  = mem_rd;
          idx_nxt   = idx_r + 1'b1;
          state_nxt = S_FR_RD;
        end else begin
          next_nxt     = mem_rd;
          has_next_nxt = 1'b1;
          state_nxt    = S_FR_PREV;
        end
      end

      S_FR_PREV: begin
        alu_req = '{op: ALU_ADD, a: {1'b0, prev_r.base}, b: {1'b0, prev_r.len}};
        if ((idx_r != '0) && (alu_res[SPAN_W-1:0] == {1'b0, base_r})) begin
          state_nxt = S_FR_MPREV;
        end else begin
          state_nxt = S_FR_NEXT;
        end
      end

      S_FR_MPREV: begin
        alu_req      = '{op: ALU_ADD, a: {1'b0, prev_r.len}, b: {1'b0, size_r}};
        prev_nxt.len = alu_sat;
        state_nxt    = S_FR_MDEC;
      end

      S_FR_MDEC: begin
        alu_req = '{op: ALU_ADD, a: {1'b0, prev_r.len}, b: {1'b0, next_r.len}};
        if (next_hit) begin
          // range bridges both neighbors: fold the next one in and drop it
          mem_wr    = '{en: 1'b1, addr: idx_r - 1'b1,
                        data: '{base: prev_r.base, len: alu_sat}};
          ptr_nxt   = idx_r;
          state_nxt = S_SHD_RD;
        end else begin
          mem_wr    = '{en: 1'b1, addr: idx_r - 1'b1, data: prev_r};
          state_nxt = S_RESP;
        end
      end

      S_FR_NEXT: begin
        alu_req = '{op: ALU_ADD, a: {1'b0, next_r.len}, b: {1'b0, size_r}};
        if (next_hit) begin
          mem_wr    = '{en: 1'b1, addr: idx_r,
                        data: '{base: base_r, len: alu_sat}};
          state_nxt = S_RESP;
        end else if (used_r == USABLE_SLOTS) begin
          status_nxt = ST_FULL;
          state_nxt  = S_RESP;
        end else begin
          ptr_nxt   = used_r;
          state_nxt = S_SHU_RD;
        end
      end

      // ---- shift entries down over slot ptr ----
      S_SHD_RD: begin
        if (ptr_inc_w == {1'b0, used_r}) begin
          used_nxt  = used_r - 1'b1;
          state_nxt = S_RESP;
        end else begin
          mem_rd_addr = ptr_inc_w[IDX_W-1:0];
          state_nxt   = S_SHD_WR;
        end
      end

      S_SHD_WR: begin
        mem_wr    = '{en: 1'b1, addr: ptr_r, data: mem_rd};
        ptr_nxt   = ptr_inc_w[IDX_W-1:0];
        state_nxt = S_SHD_RD;
      end

      // ---- shift entries up to open slot idx ----
      S_SHU_RD: begin
        if (ptr_r == idx_r) begin
          mem_wr    = '{en: 1'b1, addr: idx_r,
                        data: '{base: base_r, len: size_r}};
          used_nxt  = used_r + 1'b1;
          state_nxt = S_RESP;
        end else begin
          mem_rd_addr = ptr_r - 1'b1;
          state_nxt   = S_SHU_WR;
        end
      end

      S_SHU_WR: begin
        mem_wr    = '{en: 1'b1, addr: ptr_r, data: mem_rd};
        ptr_nxt   = ptr_r - 1'b1;
        state_nxt = S_SHU_RD;
      end

      S_RESP: begin
        state_nxt = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy             = (state_r != S_IDLE);
  assign out_valid        = (state_r == S_RESP);
  assign out_granted_base = granted_r;
  assign out_status       = status_r;

endmodule

`default_nettype wire

### rtl/ffea_checker.sv
// ----------------------------------------------------------------------------
// ffea_checker: port-level checks for the first-fit extent allocator
// Watches the command handshake and the result strobe on the top-level ports.
// ----------------------------------------------------------------------------
`default_nettype none

module ffea_checker
  import ffea_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        start,
  input wire logic        busy,
  input wire logic        in_command,
  input wire logic [15:0] in_request_size,
  input wire logic [15:0] in_free_base,
  input wire logic        out_valid,
  input wire logic [15:0] out_granted_base,
  input wire logic [1:0]  out_status
);

  // an accepted word holds the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy not raised after accepted request");

  // result strobe lasts one cycle and frees the block
  a_resp_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> (!out_valid && !busy))
    else $error("result strobe not followed by idle");

  // zero-size request answers right away with the zero-size code
  a_zero_fast: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_request_size == 16'd0)) |=>
      (out_valid && (out_status == ST_ZERO)))
    else $error("zero-size request not answered next cycle");

  // any status but a grant carries base zero
  a_fail_base: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != ST_OK)) |-> (out_granted_base == 16'd0))
    else $error("nonzero base on failed or ignored request");

endmodule

bind first_fit_extent_allocator ffea_checker u_ffea_checker (.*);

`default_nettype wire

### sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the first-fit extent allocator
// Drives request words through the start/busy handshake and predicts every
// result word from a behavioral copy of the extent table. A short table of
// directed words covers reset, zero sizes, clipping, merges and saturation.
// Random episodes then fill the table to overflow, churn grants and add noise.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ffea_pkg::*;

  localparam int SLOTS        = MAP_ENTRIES - 1;
  localparam int SPAN         = 65536;
  localparam int SAT_MAX      = 65535;
  localparam int RANDOM_WORDS = 950;
  localparam int N_PROBES     = 25;
  localparam int TAIL_START   = N_PROBES + RANDOM_WORDS - 80;
  localparam int FILL_SLOTS   = 72;
  localparam int CYCLE_LIMIT  = 1500000;

  typedef struct packed {
    addr_t   base;
    status_t st;
  } answer_t;

  typedef struct packed {
    addr_t base;
    addr_t size;
  } grant_t;

  typedef struct packed {
    cmd_t    cmd;
    addr_t   size;
    addr_t   base;
    logic    typed;
    addr_t   want_base;
    status_t want_st;
  } probe_t;

  logic        clk             = 1'b0;
  logic        rst_n           = 1'b0;
  logic        start           = 1'b0;
  logic        busy;
  logic        in_command      = 1'b0;
  logic [15:0] in_request_size = '0;
  logic [15:0] in_free_base    = '0;
  logic        out_valid;
  logic [15:0] out_granted_base;
  logic [1:0]  out_status;

  // free extent table as the block should hold it
  addr_t map_base [MAP_ENTRIES];
  addr_t map_len  [MAP_ENTRIES];
  int    map_used = 0;

  answer_t     due_answers [$];
  grant_t      live_grants [$];
  int          err_count   = 0;
  int          words_sent  = 0;
  int unsigned cycle_count = 0;
  bit          gaps_on     = 1'b1;
  bit          hold_for_drain = 1'b0;

  probe_t probes [N_PROBES] = '{
    '{CMD_ALLOC, 16'd1,      16'h1234, 1'b1, 16'h0000, ST_NO_FIT},
    '{CMD_FREE,  16'd0,      16'd100,  1'b1, 16'h0000, ST_ZERO},
    '{CMD_ALLOC, 16'd0,      16'hFFFF, 1'b1, 16'h0000, ST_ZERO},
    '{CMD_FREE,  16'd100,    16'd0,    1'b1, 16'h0000, ST_OK},
    '{CMD_ALLOC, 16'd10,     16'd0,    1'b1, 16'h0000, ST_OK},
    '{CMD_ALLOC, 16'd90,     16'd0,    1'b1, 16'd10,   ST_OK},
    '{CMD_ALLOC, 16'd1,      16'd0,    1'b1, 16'h0000, ST_NO_FIT},
    '{CMD_FREE,  16'hFFFF,   16'hFFF0, 1'b1, 16'h0000, ST_OK},
    '{CMD_ALLOC, 16'd17,     16'd0,    1'b1, 16'h0000, ST_NO_FIT},
    '{CMD_ALLOC, 16'd16,     16'd0,    1'b1, 16'hFFF0, ST_OK},
    '{CMD_FREE,  16'd100,    16'd1000, 1'b0, 16'h0000, ST_OK},
    '{CMD_FREE,  16'd50,     16'd1200, 1'b0, 16'h0000, ST_OK},
    '{CMD_FREE,  16'd100,    16'd1100, 1'b0, 16'h0000, ST_OK},
    '{CMD_ALLOC, 16'd251,    16'd0,    1'b0, 16'h0000, ST_OK},
    '{CMD_ALLOC, 16'd250,    16'd0,    1'b0, 16'h0000, ST_OK},
    '{CMD_FREE,  16'hFFFF,   16'd0,    1'b0, 16'h0000, ST_OK},
    '{CMD_FREE,  16'd1,      16'hFFFF, 1'b0, 16'h0000, ST_OK},
    '{CMD_FREE,  16'hFFFF,   16'd0,    1'b0, 16'h0000, ST_OK},
    '{CMD_FREE,  16'h8000,   16'h4000, 1'b0, 16'h0000, ST_OK},
    '{CMD_ALLOC, 16'hFFFF,   16'd0,    1'b0, 16'h0000, ST_OK},
    '{CMD_ALLOC, 16'hFFFF,   16'h5555, 1'b0, 16'h0000, ST_OK},
    '{CMD_ALLOC, 16'hFFFF,   16'd0,    1'b0, 16'h0000, ST_OK},
    '{CMD_FREE,  16'hFFFF,   16'hFFFF, 1'b0, 16'h0000, ST_OK},
    '{CMD_ALLOC, 16'hFFFF,   16'hAAAA, 1'b0, 16'h0000, ST_OK},
    '{CMD_ALLOC, 16'd1,      16'd0,    1'b0, 16'h0000, ST_OK}
  };

  first_fit_extent_allocator u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_command       (in_command),
    .in_request_size  (in_request_size),
    .in_free_base     (in_free_base),
    .out_valid        (out_valid),
    .out_granted_base (out_granted_base),
    .out_status       (out_status)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic addr_t sat_len(input int v);
    return (v > SAT_MAX) ? addr_t'(SAT_MAX) : addr_t'(v);
  endfunction

  function automatic void drop_extent(input int idx);
    int k;
    for (k = idx; k + 1 < map_used; k++) begin
      map_base[k] = map_base[k+1];
      map_len[k]  = map_len[k+1];
    end
    map_used--;
  endfunction

  function automatic void predict_answer(input cmd_t cmd, input addr_t size,
                                         input addr_t fbase, output answer_t ans);
    int b, sz, e, i, k;
    ans = '{base: '0, st: ST_OK};
    if (size == 0) begin
      ans.st = ST_ZERO;
    end else if (cmd == CMD_ALLOC) begin
      ans.st = ST_NO_FIT;
      for (i = 0; i < map_used; i++) begin
        if (map_len[i] >= size) begin
          ans.base    = map_base[i];
          ans.st      = ST_OK;
          map_base[i] = map_base[i] + size;
          map_len[i]  = map_len[i] - size;
          if (map_len[i] == 0) drop_extent(i);
          break;
        end
      end
    end else begin
      b  = int'(fbase);
      sz = int'(size);
      // clip the range at the top of the address space
      if (b + sz > SPAN) sz = SPAN - b;
      e = b + sz;
      i = 0;
      while (i < map_used && int'(map_base[i]) <= b) i++;
      if (i > 0 && int'(map_base[i-1]) + int'(map_len[i-1]) == b) begin
        map_len[i-1] = sat_len(int'(map_len[i-1]) + sz);
        if (i < map_used && e == int'(map_base[i])) begin
          map_len[i-1] = sat_len(int'(map_len[i-1]) + int'(map_len[i]));
          drop_extent(i);
        end
      end else if (i < map_used && e == int'(map_base[i])) begin
        map_base[i] = addr_t'(b);
        map_len[i]  = sat_len(int'(map_len[i]) + sz);
      end else if (map_used >= SLOTS) begin
        ans.st = ST_FULL;
      end else begin
        for (k = map_used; k > i; k--) begin
          map_base[k] = map_base[k-1];
          map_len[k]  = map_len[k-1];
        end
        map_base[i] = addr_t'(b);
        map_len[i]  = sat_len(sz);
        map_used++;
      end
    end
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t mismatch %s: got %0h want %0h", $time, what, got, want);
    err_count++;
  endtask

  // Present one request word and hold it until the block takes it.
  task automatic issue_request(input cmd_t cmd, input addr_t size, input addr_t fbase,
                               input bit typed, input addr_t want_base,
                               input status_t want_st);
    int      gap;
    answer_t ans;
    gap = 0;
    if (words_sent >= TAIL_START) gaps_on = 1'b0;
    else if ($urandom_range(0, 31) == 0) gaps_on = !gaps_on;
    if (gaps_on && $urandom_range(0, 2) == 0) gap = $urandom_range(1, 6);
    if (hold_for_drain && gap == 0) gap = 1;
    if (gap > 0) begin
      start <= 1'b0;
      while (hold_for_drain && due_answers.size() != 0) @(posedge clk);
      repeat (gap) @(posedge clk);
      hold_for_drain = 1'b0;
    end
    start           <= 1'b1;
    in_command      <= cmd;
    in_request_size <= size;
    in_free_base    <= fbase;
    do @(posedge clk); while (busy);
    predict_answer(cmd, size, fbase, ans);
    if (cmd == CMD_ALLOC && ans.st == ST_OK) begin
      live_grants.push_back('{base: ans.base, size: size});
      if (live_grants.size() > 256) void'(live_grants.pop_front());
    end
    if (typed) ans = '{base: want_base, st: want_st};
    due_answers.push_back(ans);
    words_sent++;
  endtask

  task automatic send_checked(input cmd_t cmd, input addr_t size, input addr_t fbase);
    issue_request(cmd, size, fbase, 1'b0, '0, ST_OK);
  endtask

  // Empty the table, free spaced ranges in random order past the point where it
  // overflows, then allocate from the fragments.
  task automatic fill_episode();
    int slot_order [FILL_SLOTS];
    int j, k, tmp;
    while (map_used > 0) send_checked(CMD_ALLOC, map_len[0], addr_t'($urandom()));
    for (j = 0; j < FILL_SLOTS; j++) slot_order[j] = j;
    for (j = FILL_SLOTS - 1; j > 0; j--) begin
      k = $urandom_range(0, j);
      tmp = slot_order[j];
      slot_order[j] = slot_order[k];
      slot_order[k] = tmp;
    end
    // gaps of at least 100 units keep neighbors from merging
    for (j = 0; j < FILL_SLOTS; j++)
      send_checked(CMD_FREE, addr_t'($urandom_range(1, 400)),
                   addr_t'(slot_order[j] * 900 + $urandom_range(0, 400)));
    hold_for_drain = 1'b1;
    repeat (20) send_checked(CMD_ALLOC, addr_t'($urandom_range(1, 500)), addr_t'($urandom()));
  endtask

  task automatic churn_episode();
    int     pick, k;
    grant_t g;
    repeat (30) begin
      pick = $urandom_range(0, 9);
      if (pick < 5 || (pick < 9 && live_grants.size() == 0)) begin
        if ($urandom_range(0, 7) == 0)
          send_checked(CMD_ALLOC, addr_t'($urandom_range(1, 16'hFFFF)), addr_t'($urandom()));
        else
          send_checked(CMD_ALLOC, addr_t'($urandom_range(1, 64)), addr_t'($urandom()));
      end else if (pick < 9) begin
        // give back a grant whole
        k = $urandom_range(0, live_grants.size() - 1);
        g = live_grants[k];
        live_grants.delete(k);
        send_checked(CMD_FREE, g.size, g.base);
      end else begin
        send_checked(CMD_FREE, addr_t'($urandom_range(1, 2048)), addr_t'($urandom()));
      end
    end
  endtask

  task automatic noise_episode();
    addr_t size;
    repeat (15) begin
      case ($urandom_range(0, 3))
        0:       size = '0;
        1:       size = 16'hFFFF;
        2:       size = addr_t'($urandom());
        default: size = addr_t'($urandom_range(1, 32));
      endcase
      send_checked(cmd_t'($urandom_range(0, 1)), size, addr_t'($urandom()));
    end
  endtask

  // Take every result word in its strobe cycle and compare with the oldest due.
  always @(posedge clk) begin
    answer_t want;
    if (rst_n && out_valid) begin
      if (due_answers.size() == 0) begin
        report_mismatch("result with nothing due", out_granted_base, 0);
      end else begin
        want = due_answers.pop_front();
        if (out_granted_base !== want.base)
          report_mismatch("granted_base", out_granted_base, want.base);
        if (out_status !== want.st)
          report_mismatch("status", out_status, want.st);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  initial begin
    int  j;
    bit  first_fill;
    first_fill = 1'b1;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    for (j = 0; j < N_PROBES; j++)
      issue_request(probes[j].cmd, probes[j].size, probes[j].base, probes[j].typed,
                    probes[j].want_base, probes[j].want_st);
    while (words_sent < N_PROBES + RANDOM_WORDS) begin
      if (first_fill) begin
        fill_episode();
        first_fill = 1'b0;
      end else begin
        case ($urandom_range(0, 9))
          0, 1:             fill_episode();
          2, 3, 4, 5, 6, 7: churn_episode();
          default:          noise_episode();
        endcase
      end
    end
    start <= 1'b0;
    while (due_answers.size() != 0) @(posedge clk);
    // watch for stray words after the last answer
    repeat (300) @(posedge clk);
    if (err_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

### sim.f
rtl/ffea_pkg.sv
rtl/ffea_alu.sv
rtl/ffea_mem.sv
rtl/first_fit_extent_allocator.sv
rtl/ffea_checker.sv
sim/tb_top.sv
